[rtl/core/svf_cascade_coeff_smoothing_assert.svh]
// assertion macros for the state-variable filter cascade
// used by the top level; no other dependencies
`ifndef SVF_CASCADE_COEFF_SMOOTHING_ASSERT_SVH
`define SVF_CASCADE_COEFF_SMOOTHING_ASSERT_SVH
`ifndef SYNTHESIS
`define SVFC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svfc check failed");
`define SVFC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svfc check failed");
`else
`define SVFC_ASSERT_IMP(lbl, ante, cons)
`define SVFC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/svfc_pkg.sv]
// shared constants, types and arithmetic helpers for the filter cascade
// no dependencies
package svfc_pkg;

    localparam int SECTIONS   = 8;
    localparam int CHANNELS   = 2;
    localparam int NCOEF      = 6;
    localparam int COEF_DEPTH = SECTIONS * NCOEF;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int SEC_W      = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    localparam logic signed [31:0] ONE_Q24   = 32'sh0100_0000;
    localparam logic [24:0]        ALPHA_ONE = 25'h100_0000;

    localparam logic [2:0] COEF_A1 = 3'd0;
    localparam logic [2:0] COEF_A2 = 3'd1;
    localparam logic [2:0] COEF_A3 = 3'd2;
    localparam logic [2:0] COEF_M0 = 3'd3;
    localparam logic [2:0] COEF_M1 = 3'd4;
    localparam logic [2:0] COEF_M2 = 3'd5;

    typedef logic [NCOEF-1:0][31:0] coef_bank_t;

    typedef enum logic [1:0] {
        LANE_IN,
        LANE_SEC,
        LANE_OUT
    } lane_op_t;

    typedef struct packed {
        logic             valid;
        lane_op_t         op;
        logic [SEC_W-1:0] sec;
    } lane_cmd_t;

    typedef struct packed {
        logic start;
        logic first;
    } smooth_cmd_t;

    function automatic logic signed [63:0] rnd(input logic signed [63:0] p, input int s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        return (p + half) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_007F_FFFF)
            return 24'sh7F_FFFF;
        else if (v < -64'sh0000_0000_0080_0000)
            return 24'sh80_0000;
        else
            return v[23:0];
    endfunction

endpackage

[rtl/core/svfc_ram.sv]
// generic single-write, single-read ram with registered read
// no dependencies
module svfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/svfc_smooth.sv]
// coefficient smoothing unit: moves current coefficients toward targets
// depends on svfc_pkg and svfc_ram
module svfc_smooth
    import svfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  smooth_cmd_t        cmd,
    input  logic [24:0]        alpha,
    input  logic               tgt_we,
    input  logic [COEF_AW-1:0] tgt_waddr,
    input  logic [31:0]        tgt_wdata,
    output logic               done,
    output coef_bank_t         bank
);

    typedef enum logic [1:0] {
        SM_IDLE,
        SM_READ,
        SM_MUL,
        SM_WRITE
    } sm_state_t;

    sm_state_t                 state_reg, state_next;
    logic [COEF_AW-1:0]        addr_reg, addr_next;
    logic [2:0]                sel_reg, sel_next;
    logic [COEF_DEPTH-1:0]     cur_vld_reg, cur_vld_next;
    logic [COEF_DEPTH-1:0]     tgt_vld_reg, tgt_vld_next;
    logic signed [58:0]        prod_reg, prod_next;
    logic signed [31:0]        hold_reg, hold_next;
    logic                      done_reg, done_next;
    coef_bank_t                bank_reg, bank_next;

    logic [31:0]               cur_rdata, tgt_rdata;
    logic signed [31:0]        cur_v, tgt_v, rst_v, new_c;
    logic signed [32:0]        diff;
    logic [24:0]               alpha_eff;
    logic                      cur_we;

    svfc_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (addr_reg),
        .wdata (new_c),
        .raddr (addr_reg),
        .rdata (cur_rdata)
    );

    svfc_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (tgt_waddr),
        .wdata (tgt_wdata),
        .raddr (addr_reg),
        .rdata (tgt_rdata)
    );

    always_comb
    begin
        alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
        rst_v = (sel_reg == COEF_M0) ? ONE_Q24 : 32'sd0;
        cur_v = cur_vld_reg[addr_reg] ? $signed(cur_rdata) : rst_v;
        tgt_v = tgt_vld_reg[addr_reg] ? $signed(tgt_rdata) : rst_v;
        diff  = 33'(tgt_v) - 33'(cur_v);
        new_c = sat32(64'(hold_reg) + rnd(64'(prod_reg), 24));
        cur_we = (state_reg == SM_WRITE);

        state_next   = state_reg;
        addr_next    = addr_reg;
        sel_next     = sel_reg;
        cur_vld_next = cur_vld_reg;
        tgt_vld_next = tgt_vld_reg;
        prod_next    = prod_reg;
        hold_next    = hold_reg;
        done_next    = 1'b0;
        bank_next    = bank_reg;

        if (tgt_we)
        begin
            tgt_vld_next[tgt_waddr] = 1'b1;
        end

        case (state_reg)
            SM_IDLE:
            begin
                if (cmd.start)
                begin
                    sel_next   = COEF_A1;
                    state_next = SM_READ;
                    if (cmd.first)
                    begin
                        addr_next = '0;
                    end
                end
            end
            SM_READ:
            begin
                state_next = SM_MUL;
            end
            SM_MUL:
            begin
                prod_next  = $signed({1'b0, alpha_eff}) * diff;
                hold_next  = cur_v;
                state_next = SM_WRITE;
            end
            SM_WRITE:
            begin
                cur_vld_next[addr_reg] = 1'b1;
                bank_next[sel_reg]     = new_c;
                addr_next              = addr_reg + 1'b1;
                if (sel_reg == COEF_M2)
                begin
                    done_next  = 1'b1;
                    state_next = SM_IDLE;
                end
                else
                begin
                    sel_next   = sel_reg + 3'd1;
                    state_next = SM_READ;
                end
            end
            default:
            begin
                state_next = SM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SM_IDLE;
            addr_reg    <= '0;
            sel_reg     <= COEF_A1;
            cur_vld_reg <= '0;
            tgt_vld_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            sel_reg     <= sel_next;
            cur_vld_reg <= cur_vld_next;
            tgt_vld_reg <= tgt_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        hold_reg <= hold_next;
        bank_reg <= bank_next;
    end

    assign done = done_reg;
    assign bank = bank_reg;

endmodule

[rtl/core/svfc_lane.sv]
// one channel lane: input gain, filter sections on a shared multiplier, output gain
// depends on svfc_pkg
module svfc_lane
    import svfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lane_cmd_t          cmd,
    input  coef_bank_t         bank,
    input  logic signed [23:0] samp,
    input  logic [23:0]        in_gain,
    input  logic [23:0]        out_gain,
    output logic               done,
    output logic [23:0]        result
);

    logic                busy_reg, busy_next;
    lane_op_t            op_reg, op_next;
    logic [SEC_W-1:0]    sec_reg, sec_next;
    logic [2:0]          step_reg, step_next;
    logic signed [31:0]  x_reg, x_next;
    logic signed [31:0]  v1_reg, v1_next;
    logic signed [31:0]  v2_reg, v2_next;
    logic signed [31:0]  v3_reg, v3_next;
    logic signed [41:0]  acc_reg, acc_next;
    logic signed [42:0]  accy_reg, accy_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic signed [31:0]  i1_reg [SECTIONS];
    logic signed [31:0]  i1_next [SECTIONS];
    logic signed [31:0]  i2_reg [SECTIONS];
    logic signed [31:0]  i2_next [SECTIONS];
    logic [23:0]         res_reg, res_next;
    logic                done_reg, done_next;

    logic signed [31:0]  mul_a, mul_b, i1, i2;
    logic signed [63:0]  r24;

    always_comb
    begin
        i1  = i1_reg[sec_reg];
        i2  = i2_reg[sec_reg];
        r24 = rnd(prod_reg, 24);

        busy_next = busy_reg;
        op_next   = op_reg;
        sec_next  = sec_reg;
        step_next = step_reg;
        x_next    = x_reg;
        v1_next   = v1_reg;
        v2_next   = v2_reg;
        v3_next   = v3_reg;
        acc_next  = acc_reg;
        accy_next = accy_reg;
        i1_next   = i1_reg;
        i2_next   = i2_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        mul_a     = '0;
        mul_b     = '0;

        if (!busy_reg)
        begin
            if (cmd.valid)
            begin
                busy_next = 1'b1;
                op_next   = cmd.op;
                sec_next  = cmd.sec;
                step_next = '0;
            end
        end
        else
        begin
            step_next = step_reg + 3'd1;
            case (op_reg)
                LANE_IN:
                begin
                    mul_a = 32'(samp);
                    mul_b = $signed({8'd0, in_gain});
                    if (step_reg == 3'd1)
                    begin
                        x_next    = sat32(rnd(prod_reg, 19));
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                LANE_OUT:
                begin
                    mul_a = x_reg;
                    mul_b = $signed({8'd0, out_gain});
                    if (step_reg == 3'd1)
                    begin
                        res_next  = sat24(rnd(prod_reg, 21));
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                LANE_SEC:
                begin
                    case (step_reg)
                        3'd0:
                        begin
                            v3_next = sat32(64'(x_reg) - 64'(i2));
                            mul_a   = $signed(bank[COEF_A1]);
                            mul_b   = i1;
                        end
                        3'd1:
                        begin
                            acc_next = r24[41:0];
                            mul_a    = $signed(bank[COEF_A2]);
                            mul_b    = v3_reg;
                        end
                        3'd2:
                        begin
                            v1_next = sat32(64'(acc_reg) + r24);
                            mul_a   = $signed(bank[COEF_M0]);
                            mul_b   = x_reg;
                        end
                        3'd3:
                        begin
                            accy_next = r24[42:0];
                            mul_a     = $signed(bank[COEF_A2]);
                            mul_b     = v1_reg;
                        end
                        3'd4:
                        begin
                            acc_next = 42'(64'(i2) + r24);
                            mul_a    = $signed(bank[COEF_A3]);
                            mul_b    = v3_reg;
                        end
                        3'd5:
                        begin
                            v2_next          = sat32(64'(acc_reg) + r24);
                            i1_next[sec_reg] = sat32(64'(v1_reg) * 2 - 64'(i1));
                            mul_a            = $signed(bank[COEF_M1]);
                            mul_b            = v1_reg;
                        end
                        3'd6:
                        begin
                            accy_next        = 43'(64'(accy_reg) + r24);
                            i2_next[sec_reg] = sat32(64'(v2_reg) * 2 - 64'(i2));
                            mul_a            = $signed(bank[COEF_M2]);
                            mul_b            = v2_reg;
                        end
                        default:
                        begin
                            x_next    = sat32(64'(accy_reg) + r24);
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg   <= LANE_IN;
            sec_reg  <= '0;
            step_reg <= '0;
            done_reg <= 1'b0;
            for (int k = 0; k < SECTIONS; k++)
            begin
                i1_reg[k] <= '0;
                i2_reg[k] <= '0;
            end
        end
        else
        begin
            busy_reg <= busy_next;
            op_reg   <= op_next;
            sec_reg  <= sec_next;
            step_reg <= step_next;
            done_reg <= done_next;
            i1_reg   <= i1_next;
            i2_reg   <= i2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        v1_reg   <= v1_next;
        v2_reg   <= v2_next;
        v3_reg   <= v3_next;
        acc_reg  <= acc_next;
        accy_reg <= accy_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[rtl/core/svfc_merge.sv]
// merges lane results into one output item held in a register
// depends on svfc_pkg
module svfc_merge
    import svfc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic [CHANNELS-1:0][23:0] lane_res,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [47:0]               m_axis_tdata
);

    logic        valid_reg, valid_next;
    logic [47:0] data_reg, data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (valid_reg && m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                data_next[c*24 +: 24] = lane_res[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

[rtl/core/svf_cascade_coeff_smoothing.sv]
// a load item writes one target coefficient and leaves the block idle; a sample item
// runs input gain, then smoothing and the filter for each section, then output gain
// no new item is accepted until a sample item is in the output register; each section
// waits on the smoothing unit, one coefficient at a time, then on the lane multiplier
// reset: asynchronous active low; coefficient stores read as bypass until written
// depends on svfc_pkg, svfc_smooth, svfc_lane, svfc_merge
`include "svf_cascade_coeff_smoothing_assert.svh"
module svf_cascade_coeff_smoothing
    import svfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left_in[23:0], right_in[47:24], in_gain[71:48], out_gain[95:72],
    // section[98:96], coeff_select[101:99], coeff_value[133:102], zero fill
    input  logic [135:0] s_axis_tdata,
    // action
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // left_out[23:0], right_out[47:24]
    output logic [47:0]  m_axis_tdata,
    input  logic         cfg_wr_en,
    input  logic [24:0]  cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IN,
        ST_SMOOTH,
        ST_SEC,
        ST_OUT,
        ST_DELIVER
    } state_t;

    state_t             state_reg, state_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [24:0]        alpha_reg;
    lane_cmd_t          lane_cmd_reg, lane_cmd_next;
    smooth_cmd_t        smooth_cmd_reg, smooth_cmd_next;
    logic               merge_load;
    logic signed [23:0] samp_reg [2];
    logic [23:0]        gin_reg, gout_reg;

    logic                      accept, load_item, tgt_we, smooth_done, lane_done;
    logic [2:0]                ld_sec, ld_sel;
    logic [COEF_AW-1:0]        tgt_waddr;
    coef_bank_t                bank;
    logic [CHANNELS-1:0]       lane_done_vec;
    logic [CHANNELS-1:0][23:0] lane_res;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign load_item = s_axis_tuser[0];
    assign ld_sec    = s_axis_tdata[98:96];
    assign ld_sel    = s_axis_tdata[101:99];
    assign tgt_we    = accept && load_item && (int'(ld_sec) < SECTIONS) && (int'(ld_sel) < NCOEF);
    assign tgt_waddr = COEF_AW'(int'(ld_sec) * NCOEF + int'(ld_sel));
    assign lane_done = &lane_done_vec;
    assign s_axis_tready = (state_reg == ST_IDLE);

    svfc_smooth u_smooth (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (smooth_cmd_reg),
        .alpha     (alpha_reg),
        .tgt_we    (tgt_we),
        .tgt_waddr (tgt_waddr),
        .tgt_wdata (s_axis_tdata[133:102]),
        .done      (smooth_done),
        .bank      (bank)
    );

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        svfc_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (lane_cmd_reg),
            .bank     (bank),
            .samp     (samp_reg[c]),
            .in_gain  (gin_reg),
            .out_gain (gout_reg),
            .done     (lane_done_vec[c]),
            .result   (lane_res[c])
        );
    end

    svfc_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (merge_load),
        .lane_res      (lane_res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        sec_next        = sec_reg;
        lane_cmd_next   = '0;
        smooth_cmd_next = '0;
        merge_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !load_item)
                begin
                    lane_cmd_next.valid = 1'b1;
                    lane_cmd_next.op    = LANE_IN;
                    state_next          = ST_IN;
                end
            end
            ST_IN:
            begin
                if (lane_done)
                begin
                    sec_next              = '0;
                    smooth_cmd_next.start = 1'b1;
                    smooth_cmd_next.first = 1'b1;
                    state_next            = ST_SMOOTH;
                end
            end
            ST_SMOOTH:
            begin
                if (smooth_done)
                begin
                    lane_cmd_next.valid = 1'b1;
                    lane_cmd_next.op    = LANE_SEC;
                    lane_cmd_next.sec   = sec_reg;
                    state_next          = ST_SEC;
                end
            end
            ST_SEC:
            begin
                if (lane_done)
                begin
                    if (sec_reg == SEC_W'(SECTIONS - 1))
                    begin
                        lane_cmd_next.valid = 1'b1;
                        lane_cmd_next.op    = LANE_OUT;
                        state_next          = ST_OUT;
                    end
                    else
                    begin
                        sec_next              = sec_reg + 1'b1;
                        smooth_cmd_next.start = 1'b1;
                        state_next            = ST_SMOOTH;
                    end
                end
            end
            ST_OUT:
            begin
                if (lane_done)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (!m_axis_tvalid || m_axis_tready)
                begin
                    merge_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sec_reg        <= '0;
            alpha_reg      <= ALPHA_ONE;
            lane_cmd_reg   <= '0;
            smooth_cmd_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sec_reg        <= sec_next;
            lane_cmd_reg   <= lane_cmd_next;
            smooth_cmd_reg <= smooth_cmd_next;
            if (cfg_wr_en)
            begin
                alpha_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !load_item)
        begin
            samp_reg[0] <= $signed(s_axis_tdata[23:0]);
            samp_reg[1] <= $signed(s_axis_tdata[47:24]);
            gin_reg     <= s_axis_tdata[71:48];
            gout_reg    <= s_axis_tdata[95:72];
        end
    end

    `SVFC_ASSERT_NXT(a_sample_busy, accept && !load_item, !s_axis_tready)
    `SVFC_ASSERT_NXT(a_load_idle, accept && load_item, s_axis_tready)
    `SVFC_ASSERT_IMP(a_no_overwrite, merge_load, !m_axis_tvalid || m_axis_tready)
    `SVFC_ASSERT_IMP(a_units_apart, smooth_done, !lane_done)

endmodule
